// ===== src/npcq_pkg.sv =====
// Package for the nearest palette color quantizer.
// Holds the palette tables, the shared types and the search state encoding.
// No dependencies.
package npcq_pkg;

	localparam int PALETTE_ENTRIES_DEF = 256;
	localparam int COMP_W = 8;
	localparam int DIST_W = 18;
	// Starting bound: every squared distance (at most 195075) is below it.
	localparam logic [DIST_W-1:0] DIST_INIT = 18'd198025;
	localparam int CUBE_START = 16;
	localparam int GRAY_START = 232;
	localparam logic [7:0] GRAY_FIRST = 8'd18;
	localparam logic [7:0] GRAY_STEP = 8'd10;
	localparam logic [2:0] CUBE_TOP = 3'd5;

	localparam logic [1:0] SEL_PAL8 = 2'd0;
	localparam logic [1:0] SEL_PAL16 = 2'd1;
	localparam logic [1:0] SEL_PAL256 = 2'd2;

	typedef struct packed {
		logic [COMP_W-1:0] r;
		logic [COMP_W-1:0] g;
		logic [COMP_W-1:0] b;
	} rgb_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_DONE
	} scan_state_t;

	function automatic rgb_t pal8_rgb(input logic [2:0] idx);
		rgb_t c;
		unique case (idx)
			3'd0: c = '{8'd0, 8'd0, 8'd0};
			3'd1: c = '{8'd250, 8'd75, 8'd75};
			3'd2: c = '{8'd24, 8'd178, 8'd24};
			3'd3: c = '{8'd178, 8'd104, 8'd24};
			3'd4: c = '{8'd192, 8'd0, 8'd0};
			3'd5: c = '{8'd225, 8'd30, 8'd225};
			3'd6: c = '{8'd24, 8'd178, 8'd178};
			default: c = '{8'd178, 8'd178, 8'd178};
		endcase
		return c;
	endfunction

	function automatic rgb_t pal16_rgb(input logic [3:0] idx);
		rgb_t c;
		unique case (idx)
			4'd0: c = '{8'd0, 8'd0, 8'd0};
			4'd1: c = '{8'd128, 8'd0, 8'd0};
			4'd2: c = '{8'd0, 8'd128, 8'd0};
			4'd3: c = '{8'd128, 8'd128, 8'd0};
			4'd4: c = '{8'd0, 8'd0, 8'd128};
			4'd5: c = '{8'd128, 8'd0, 8'd128};
			4'd6: c = '{8'd0, 8'd128, 8'd128};
			4'd7: c = '{8'd192, 8'd192, 8'd192};
			4'd8: c = '{8'd128, 8'd128, 8'd128};
			4'd9: c = '{8'd255, 8'd0, 8'd0};
			4'd10: c = '{8'd0, 8'd255, 8'd0};
			4'd11: c = '{8'd255, 8'd255, 8'd0};
			4'd12: c = '{8'd0, 8'd0, 8'd255};
			4'd13: c = '{8'd255, 8'd0, 8'd255};
			4'd14: c = '{8'd0, 8'd255, 8'd255};
			default: c = '{8'd255, 8'd255, 8'd255};
		endcase
		return c;
	endfunction

	function automatic logic [7:0] cube_level(input logic [2:0] d);
		logic [7:0] v;
		unique case (d)
			3'd0: v = 8'd0;
			3'd1: v = 8'd95;
			3'd2: v = 8'd135;
			3'd3: v = 8'd175;
			3'd4: v = 8'd215;
			default: v = 8'd255;
		endcase
		return v;
	endfunction

endpackage

// ===== src/npcq_ram.sv =====
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
module npcq_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 280,
	parameter int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/npcq_fill.sv =====
// Palette loader: after reset writes the three palettes into the palette RAM,
// one entry per cycle. Layout: 256-color at 0, 16-color next, 8-color last.
// Depends on npcq_pkg.
module npcq_fill #(
	parameter int PALETTE_ENTRIES = npcq_pkg::PALETTE_ENTRIES_DEF,
	parameter int DEPTH = PALETTE_ENTRIES + 24,
	parameter int AW = $clog2(DEPTH)
) (
	input  logic                clk,
	input  logic                arst_n,
	output logic                wr_en,
	output logic [AW-1:0]       wr_addr,
	output npcq_pkg::rgb_t      wr_data,
	output logic                fill_done
);

	localparam int CW = AW + 1;

	logic [CW-1:0] cnt_q;
	logic [2:0]    dr_q, dg_q, db_q;
	logic [7:0]    gray_q;
	logic          in_a, in_b;
	logic [7:0]    idx;
	logic [CW-1:0] off_b, off_c;
	logic          cube_step, gray_step;

	assign fill_done = (cnt_q == CW'(DEPTH));
	assign wr_en = !fill_done;
	assign wr_addr = cnt_q[AW-1:0];
	assign in_a = (cnt_q < CW'(PALETTE_ENTRIES));
	assign in_b = (cnt_q < CW'(PALETTE_ENTRIES + 16));
	assign idx = 8'(cnt_q);
	assign off_b = cnt_q - CW'(PALETTE_ENTRIES);
	assign off_c = cnt_q - CW'(PALETTE_ENTRIES + 16);

	assign cube_step = wr_en && in_a && (idx >= 8'(npcq_pkg::CUBE_START))
		&& (idx < 8'(npcq_pkg::GRAY_START));
	assign gray_step = wr_en && in_a && (idx > 8'(npcq_pkg::GRAY_START));

	always_comb begin
		if (in_a) begin
			if (idx < 8'(npcq_pkg::CUBE_START)) begin
				wr_data = npcq_pkg::pal16_rgb(idx[3:0]);
			end else if (idx < 8'(npcq_pkg::GRAY_START)) begin
				wr_data = '{npcq_pkg::cube_level(dr_q), npcq_pkg::cube_level(dg_q),
					npcq_pkg::cube_level(db_q)};
			end else if (idx == 8'(npcq_pkg::GRAY_START)) begin
				wr_data = '0;
			end else begin
				wr_data = '{gray_q, gray_q, gray_q};
			end
		end else if (in_b) begin
			wr_data = npcq_pkg::pal16_rgb(off_b[3:0]);
		end else begin
			wr_data = npcq_pkg::pal8_rgb(off_c[2:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			dr_q <= '0;
			dg_q <= '0;
			db_q <= '0;
			gray_q <= npcq_pkg::GRAY_FIRST;
		end else begin
			if (wr_en) begin
				cnt_q <= cnt_q + CW'(1);
			end
			// cube digits count blue fastest, base six
			if (cube_step) begin
				if (db_q == npcq_pkg::CUBE_TOP) begin
					db_q <= '0;
					if (dg_q == npcq_pkg::CUBE_TOP) begin
						dg_q <= '0;
						dr_q <= dr_q + 3'd1;
					end else begin
						dg_q <= dg_q + 3'd1;
					end
				end else begin
					db_q <= db_q + 3'd1;
				end
			end
			if (gray_step) begin
				gray_q <= gray_q + npcq_pkg::GRAY_STEP;
			end
		end
	end

endmodule

// ===== src/npcq_scan.sv =====
// Search engine: walks the selected palette region of the RAM, one entry per
// cycle, squared distance over two stages, keeps the first minimum.
// Depends on npcq_pkg.
module npcq_scan #(
	parameter int PALETTE_ENTRIES = npcq_pkg::PALETTE_ENTRIES_DEF,
	parameter int AW = $clog2(PALETTE_ENTRIES + 24)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fill_done,
	input  logic [1:0]          palette_select,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          red,
	input  logic [7:0]          green,
	input  logic [7:0]          blue,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [7:0]          color_index,
	output logic                rd_en,
	output logic [AW-1:0]       rd_addr,
	input  npcq_pkg::rgb_t      rd_data
);

	localparam int LIM16 = (PALETTE_ENTRIES < 16) ? PALETTE_ENTRIES : 16;

	npcq_pkg::scan_state_t state_q, state_d;

	npcq_pkg::rgb_t pix_q;
	logic [AW-1:0]  base_q;
	logic [7:0]     last_q;
	logic [7:0]     rd_cnt_q;
	logic           v_s1, v_s2;
	logic [7:0]     idx_s1, idx_s2;
	logic [15:0]    sq_r_s2, sq_g_s2, sq_b_s2;
	logic [npcq_pkg::DIST_W-1:0] best_d_q, sq_dist;
	logic [7:0]     best_i_q;
	logic           out_valid_q;
	logic [7:0]     color_index_q;
	logic           in_fire, load_out;
	logic [7:0]     dr, dg, db;

	assign in_fire = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			npcq_pkg::S_IDLE: if (in_fire) state_d = npcq_pkg::S_SCAN;
			npcq_pkg::S_SCAN: if (rd_cnt_q == last_q) state_d = npcq_pkg::S_DRAIN;
			npcq_pkg::S_DRAIN: if (!v_s1 && !v_s2) state_d = npcq_pkg::S_DONE;
			npcq_pkg::S_DONE: if (load_out) state_d = npcq_pkg::S_IDLE;
			default: state_d = npcq_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == npcq_pkg::S_IDLE) && fill_done;
		rd_en = (state_q == npcq_pkg::S_SCAN);
		load_out = (state_q == npcq_pkg::S_DONE) && (!out_valid_q || out_ready);
	end

	assign rd_addr = base_q + AW'(rd_cnt_q);

	// absolute differences against the pixel
	always_comb begin
		dr = (rd_data.r > pix_q.r) ? rd_data.r - pix_q.r : pix_q.r - rd_data.r;
		dg = (rd_data.g > pix_q.g) ? rd_data.g - pix_q.g : pix_q.g - rd_data.g;
		db = (rd_data.b > pix_q.b) ? rd_data.b - pix_q.b : pix_q.b - rd_data.b;
	end

	assign sq_dist = npcq_pkg::DIST_W'(sq_r_s2) + npcq_pkg::DIST_W'(sq_g_s2)
		+ npcq_pkg::DIST_W'(sq_b_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= npcq_pkg::S_IDLE;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1 <= rd_en;
			v_s2 <= v_s1;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			pix_q <= '{red, green, blue};
			rd_cnt_q <= '0;
			best_d_q <= npcq_pkg::DIST_INIT;
			best_i_q <= '0;
			// high bit of the selector wins, so code three acts as 256-color
			if (palette_select[1]) begin
				base_q <= '0;
				last_q <= 8'(PALETTE_ENTRIES - 1);
			end else if (palette_select[0]) begin
				base_q <= AW'(PALETTE_ENTRIES);
				last_q <= 8'(LIM16 - 1);
			end else begin
				base_q <= AW'(PALETTE_ENTRIES + 16);
				last_q <= 8'd7;
			end
		end else begin
			if (rd_en) begin
				rd_cnt_q <= rd_cnt_q + 8'd1;
			end
			// strict compare keeps the lowest index on ties
			if (v_s2 && (sq_dist < best_d_q)) begin
				best_d_q <= sq_dist;
				best_i_q <= idx_s2;
			end
		end
		idx_s1 <= rd_cnt_q;
		idx_s2 <= idx_s1;
		sq_r_s2 <= dr * dr;
		sq_g_s2 <= dg * dg;
		sq_b_s2 <= db * db;
		if (load_out) begin
			color_index_q <= best_i_q;
		end
	end

	assign out_valid = out_valid_q;
	assign color_index = color_index_q;

endmodule

// ===== src/nearest_palette_color_quantizer.sv =====
// Top level of the nearest palette color quantizer.
// Instantiates npcq_fill, npcq_ram and npcq_scan; depends on npcq_pkg.
//
// Usage:
//   Input channel in_valid/in_ready carries one pixel (red, green, blue).
//   Output channel out_valid/out_ready carries color_index, the index of the
//   palette entry nearest by squared RGB distance; lowest index on ties.
//   palette_select_we/palette_select write the palette selector
//   (0: 8 colors, 1: 16 colors, 2 or 3: 256 colors); write only while idle.
// Reset:
//   The selector resets to the 256-color palette. The palettes are loaded into
//   the palette RAM after reset, all PALETTE_ENTRIES + 24 entries; in_ready
//   stays low during the load.
// Timing:
//   The palette RAM port reads one entry per cycle; that port sets the rate.
//   With N searched entries (8, min(16,P) or P for P = PALETTE_ENTRIES) a
//   search reads the N entries, drains the distance pipeline, loads the result
//   into the output register and only then returns to idle for the next pixel.
//   A stalled receiver does not stop the next input transfer, only the loading
//   of the following result, and the search waits for that load before idle.
module nearest_palette_color_quantizer #(
	parameter int PALETTE_ENTRIES = npcq_pkg::PALETTE_ENTRIES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       palette_select_we,
	input  logic [1:0] palette_select,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] color_index
);

	// RAM holds the full 256-color region bounded by the parameter, plus 16 + 8
	localparam int DEPTH = PALETTE_ENTRIES + 24;
	localparam int AW = $clog2(DEPTH);

	logic [1:0]     palette_select_q;
	logic           fill_done;
	logic           wr_en;
	logic [AW-1:0]  wr_addr;
	npcq_pkg::rgb_t wr_data;
	logic           rd_en;
	logic [AW-1:0]  rd_addr;
	npcq_pkg::rgb_t rd_data;

	// Selector register, written with no handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			palette_select_q <= npcq_pkg::SEL_PAL256;
		end else if (palette_select_we) begin
			palette_select_q <= palette_select;
		end
	end

	// Palette loader, runs once after reset
	npcq_fill #(
		.PALETTE_ENTRIES(PALETTE_ENTRIES),
		.DEPTH(DEPTH),
		.AW(AW)
	) u_fill (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.fill_done(fill_done)
	);

	// Palette store
	npcq_ram #(
		.WIDTH($bits(npcq_pkg::rgb_t)),
		.DEPTH(DEPTH),
		.AW(AW)
	) u_ram (
		.clk(clk),
		.we(wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.re(rd_en),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	// Search over the selected region
	npcq_scan #(
		.PALETTE_ENTRIES(PALETTE_ENTRIES),
		.AW(AW)
	) u_scan (
		.clk(clk),
		.arst_n(arst_n),
		.fill_done(fill_done),
		.palette_select(palette_select_q),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.red(red),
		.green(green),
		.blue(blue),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.color_index(color_index),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// No pixel is taken before the palettes are loaded
	a_no_accept_in_fill: assert property (@(posedge clk) disable iff (!arst_n)
		!fill_done |-> !in_ready)
		else $error("input ready during palette load");

	// Load finishes once and stays finished
	a_fill_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		fill_done |=> fill_done)
		else $error("palette load restarted");

	// A transfer starts a search, so the next cycle is busy
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input ready right after a transfer");

	// Result stays inside the selected small palette
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !palette_select_q[1]) |->
		((!palette_select_q[0] && color_index < 8'd8) ||
		(palette_select_q[0] && color_index < 8'd16)))
		else $error("color index outside the selected palette");

endmodule
